@@ design/plni_pkg.sv @@
// ----------------------------------------------------------------------------
// plni_pkg
// Shared types and constants for the periodic lattice neighbour index block.
// ----------------------------------------------------------------------------
package plni_pkg;

    localparam int LEN_W  = 9;
    localparam int DIM_W  = 3;
    localparam int SITE_W = 32;
    localparam int DIR_W  = 3;
    localparam int CFG_W  = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W  = $clog2(SITE_W + 1);

    localparam int MAX_DIM_DEF   = 4;
    localparam int SITE_BITS_DEF = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4);
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_LATTICE_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION_COUNT = 1'b1;

    typedef struct packed {
        logic [SITE_W-1:0] site_index;
        logic [DIR_W-1:0]  direction;
    } in_item_t;

    typedef struct packed {
        logic [SITE_W-1:0] neighbour_index;
        logic              out_of_range;
    } out_item_t;

endpackage

@@ design/periodic_lattice_neighbour_index.sv @@
// A new site and direction are taken only when the block is idle. A beat
// passes from acceptance through the power sequencer, which forms L^dim,
// L^(dim+1) and L^D (D = dimensions in use) with one multiply a cycle and
// then flags done, then the bit-serial remainder of the site by L^(dim+1)
// (32 steps), then a state that picks the wrap and a state that forms the
// neighbour, which waits until the output register is free. A new beat is
// taken only once the result is loaded, so beats do not overlap. Requests
// found out of range skip the remainder loop. A finished result sits in the
// output register while the next beat is taken.
// ----------------------------------------------------------------------------
// periodic_lattice_neighbour_index
// Neighbour of a site on a periodic D-dimensional hypercubic lattice of
// side L, forward or backward along one dimension, with range checking.
// ----------------------------------------------------------------------------
module periodic_lattice_neighbour_index #(
    parameter int MAX_DIM   = plni_pkg::MAX_DIM_DEF,
    parameter int SITE_BITS = plni_pkg::SITE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  plni_pkg::in_item_t             in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output plni_pkg::out_item_t            out_item,
    input  logic                           cfg_we,
    input  logic [plni_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [plni_pkg::CFG_W-1:0]     cfg_data
);
    import plni_pkg::*;

    localparam int PW_W   = LEN_W * MAX_DIM;
    localparam int WIDE_W = ((PW_W > SITE_W) ? PW_W : SITE_W) + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_POW  = 5'b00010,
        S_MOD  = 5'b00100,
        S_WRAP = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [LEN_W-1:0] len_reg;
    logic [DIM_W-1:0] dims_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;

    logic [SITE_W-1:0] site_reg;
    logic              fwd_reg;
    logic [DIM_W-1:0]  dcnt_reg;
    logic [DIM_W-1:0]  dsel_reg;
    logic              err_reg;
    logic [PW_W-1:0]   thr_reg;
    logic              sub_reg;
    logic [PW_W-1:0]   add_reg;

    logic              in_accept;
    logic [DIM_W-1:0]  dcnt;
    logic              fwd;
    logic [DIM_W-1:0]  dsel;
    logic              dir_err;
    logic              site_hi;
    logic              pow_done;
    logic [PW_W-1:0]   pow_stride;
    logic [PW_W-1:0]   pow_period;
    logic [PW_W-1:0]   pow_sites;
    logic              sites_err;
    logic              mod_start;
    logic              mod_done;
    logic [PW_W-1:0]   mod_rem;
    logic              wrap;
    logic [WIDE_W-1:0] site_w;
    logic [WIDE_W-1:0] add_w;
    logic [WIDE_W-1:0] nb_wide;
    logic              nb_big;
    logic              fin_err;
    logic              out_load;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid & in_ready;

    // request decode
    assign dcnt    = (dims_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dims_reg;
    assign fwd     = (in_item.direction < dcnt);
    assign dsel    = fwd ? in_item.direction : in_item.direction - dcnt;
    assign dir_err = ({1'b0, in_item.direction} >= {dcnt, 1'b0});
    assign site_hi = ((in_item.site_index >> SITE_BITS) != '0);

    plni_pow #(
        .MAX_DIM (MAX_DIM)
    ) u_pow (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_accept),
        .len    (len_reg),
        .count  (dcnt_reg),
        .dim    (dsel_reg),
        .done   (pow_done),
        .stride (pow_stride),
        .period (pow_period),
        .sites  (pow_sites)
    );

    assign sites_err = (WIDE_W'(site_reg) >= WIDE_W'(pow_sites));
    assign mod_start = (state_reg == S_POW) && pow_done && !(err_reg || sites_err);

    plni_mod #(
        .MOD_W (PW_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (site_reg),
        .modulus  (pow_period),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // forward wraps at coordinate L-1, backward at coordinate 0
    assign wrap = fwd_reg ? (mod_rem >= thr_reg) : (mod_rem < pow_stride);

    assign site_w  = WIDE_W'(site_reg);
    assign add_w   = WIDE_W'(add_reg);
    assign nb_wide = sub_reg ? site_w - add_w : site_w + add_w;
    assign nb_big  = ((nb_wide >> SITE_BITS) != '0);
    assign fin_err = err_reg | nb_big;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_POW;
                end
            end
            S_POW:
            begin
                if (pow_done)
                begin
                    state_next = (err_reg || sites_err) ? S_OUT : S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_WRAP;
                end
            end
            S_WRAP:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= LEN_RESET;
            dims_reg      <= DIM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && (cfg_index == CFG_LATTICE_LENGTH))
            begin
                len_reg <= cfg_data[LEN_W-1:0];
            end
            if (cfg_we && (cfg_index == CFG_DIMENSION_COUNT))
            begin
                dims_reg <= cfg_data[DIM_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            site_reg <= in_item.site_index;
            fwd_reg  <= fwd;
            dcnt_reg <= dcnt;
            dsel_reg <= dsel;
            err_reg  <= dir_err | (len_reg == '0) | site_hi;
        end
        if ((state_reg == S_POW) && pow_done)
        begin
            err_reg <= err_reg | sites_err;
            thr_reg <= pow_period - pow_stride;
        end
        if (state_reg == S_WRAP)
        begin
            sub_reg <= (fwd_reg == wrap);
            add_reg <= wrap ? thr_reg : pow_stride;
        end
        if (out_load)
        begin
            out_item_reg.neighbour_index <= fin_err ? '0 : nb_wide[SITE_W-1:0];
            out_item_reg.out_of_range    <= fin_err;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTH
    a_pow_done_in_pow: assert property (@(posedge clk) disable iff (!rst_n)
        pow_done |-> state_reg == S_POW)
        else $error("power sequencer finished outside its state");

    a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> state_reg == S_MOD)
        else $error("remainder loop finished outside its state");

    a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRAP |-> mod_rem < pow_period)
        else $error("remainder not below L^(dim+1)");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.out_of_range) |-> out_item_reg.neighbour_index == '0)
        else $error("error beat carries a nonzero index");
`endif

endmodule

@@ design/plni_pow.sv @@
// ----------------------------------------------------------------------------
// plni_pow
// Power sequencer: steps L^k through k = 0..count with one multiply a cycle,
// keeping L^dim, L^(dim+1) and L^count.
// ----------------------------------------------------------------------------
module plni_pow #(
    parameter int MAX_DIM = plni_pkg::MAX_DIM_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic [plni_pkg::LEN_W-1:0]               len,
    input  logic [plni_pkg::DIM_W-1:0]               count,
    input  logic [plni_pkg::DIM_W-1:0]               dim,
    output logic                                     done,
    output logic [plni_pkg::LEN_W*MAX_DIM-1:0]       stride,
    output logic [plni_pkg::LEN_W*MAX_DIM-1:0]       period,
    output logic [plni_pkg::LEN_W*MAX_DIM-1:0]       sites
);
    import plni_pkg::*;

    localparam int PW_W = LEN_W * MAX_DIM;

    logic            busy_reg;
    logic            done_reg;
    logic [DIM_W-1:0] k_reg;
    logic [PW_W-1:0] pw_reg;
    logic [PW_W-1:0] stride_reg;
    logic [PW_W-1:0] period_reg;
    logic [PW_W-1:0] sites_reg;
    logic [PW_W-1:0] prod;
    logic [DIM_W:0]  dim_plus;

    assign prod     = pw_reg * PW_W'(len);
    assign dim_plus = {1'b0, dim} + (DIM_W+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (k_reg == count)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    k_reg <= k_reg + DIM_W'(1);
                end
            end
        end
    end

    // power chain and captures
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pw_reg <= PW_W'(1);
        end
        else if (busy_reg)
        begin
            if (k_reg == dim)
            begin
                stride_reg <= pw_reg;
            end
            if ({1'b0, k_reg} == dim_plus)
            begin
                period_reg <= pw_reg;
            end
            if (k_reg == count)
            begin
                sites_reg <= pw_reg;
            end
            else
            begin
                pw_reg <= prod;
            end
        end
    end

    assign done   = done_reg;
    assign stride = stride_reg;
    assign period = period_reg;
    assign sites  = sites_reg;

endmodule

@@ design/plni_mod.sv @@
// ----------------------------------------------------------------------------
// plni_mod
// Bit-serial remainder: shifts the site in one bit a cycle, most significant
// first, with one compare and subtract against the modulus per bit.
// ----------------------------------------------------------------------------
module plni_mod #(
    parameter int MOD_W = plni_pkg::LEN_W * plni_pkg::MAX_DIM_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [plni_pkg::SITE_W-1:0] dividend,
    input  logic [MOD_W-1:0]            modulus,
    output logic                        done,
    output logic [MOD_W-1:0]            rem
);
    import plni_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SITE_W-1:0] sh_reg;
    logic [MOD_W-1:0] r_reg;
    logic [MOD_W-1:0] mod_reg;
    logic [MOD_W:0]   trial;
    logic [MOD_W:0]   mod_ext;
    logic [MOD_W-1:0] r_next;

    assign trial   = {r_reg, sh_reg[SITE_W-1]};
    assign mod_ext = {1'b0, mod_reg};
    assign r_next  = (trial >= mod_ext) ? MOD_W'(trial - mod_ext) : trial[MOD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SITE_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= dividend;
            r_reg   <= '0;
            mod_reg <= modulus;
        end
        else if (busy_reg)
        begin
            sh_reg <= {sh_reg[SITE_W-2:0], 1'b0};
            r_reg  <= r_next;
        end
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule
